FILE: rtl/core/fat12_cluster_chain_walker_top_defines.svh
// ----------------------------------------------------------------------------
// FAT12 cluster chain walker: assertion macros
// Concurrent check macros, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef FAT12_CLUSTER_CHAIN_WALKER_TOP_DEFINES_SVH
`define FAT12_CLUSTER_CHAIN_WALKER_TOP_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define FCW_ASSERT_NOW(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (c)) \
    else $error(msg);
// next-cycle implication
`define FCW_ASSERT_NEXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (c)) \
    else $error(msg);
`else
`define FCW_ASSERT_NOW(lbl, a, c, msg)
`define FCW_ASSERT_NEXT(lbl, a, c, msg)
`endif

`endif

FILE: rtl/core/fcw_pkg.sv
// ----------------------------------------------------------------------------
// FAT12 cluster chain walker package
// Item types, codes, constants and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package fcw_pkg;

  localparam int unsigned TABLE_BYTES_DEF = 8192;
  localparam int unsigned CLUSTER_BYTES   = 512;
  localparam int unsigned ADDR_W          = 13;
  localparam int unsigned CLUSTER_W       = 12;
  localparam int unsigned SIZE_W          = 32;
  localparam int unsigned OFFSET_W        = 21;
  localparam int unsigned VALID_W         = 10;

  localparam logic [CLUSTER_W-1:0] END_MARK  = 12'hFF8;
  localparam logic [CLUSTER_W-1:0] BAD_MARK  = 12'hFF0;
  localparam logic [CLUSTER_W-1:0] FIRST_DATA_CLUSTER = 12'd2;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_START = 2'd1,
    KIND_NEXT  = 2'd2,
    KIND_RSVD  = 2'd3
  } fcw_kind_e;

  typedef enum logic [1:0] {
    ST_DATA = 2'd0,
    ST_END  = 2'd1,
    ST_BAD  = 2'd2,
    ST_IDLE = 2'd3
  } fcw_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_REPORT
  } fcw_state_e;

  typedef struct packed {
    logic [1:0]           kind;
    logic [ADDR_W-1:0]    table_address;
    logic [7:0]           table_byte;
    logic [CLUSTER_W-1:0] start_cluster;
    logic [SIZE_W-1:0]    file_size;
  } fcw_in_t;

  typedef struct packed {
    logic [CLUSTER_W-1:0] cluster;
    logic [OFFSET_W-1:0]  byte_offset;
    logic [VALID_W-1:0]   bytes_valid;
    logic [1:0]           status;
  } fcw_out_t;

  // controller -> datapath
  typedef struct packed {
    logic wr_en;      // table byte write
    logic rep_start;  // report start cluster
    logic rep_next;   // report entry just read
    logic rep_idle;   // report idle (no chain)
    logic sel_hi;     // read second byte of the entry
    logic save_lo;    // latch first byte
  } fcw_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic chain_active;
    logic out_free;
  } fcw_sts_t;

endpackage

FILE: rtl/core/fcw_datapath.sv
// ----------------------------------------------------------------------------
// FAT12 cluster chain walker datapath
// Table memory, chain state, entry extraction and the output register.
// ----------------------------------------------------------------------------
module fcw_datapath import fcw_pkg::*; #(
  parameter int unsigned TABLE_BYTES = TABLE_BYTES_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  fcw_in_t  in_item_i,
  input  fcw_cmd_t cmd_i,
  output fcw_sts_t sts_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output fcw_out_t out_item_o
);

  localparam int unsigned AW = $clog2(TABLE_BYTES);
  localparam logic [ADDR_W:0] TBL_LIMIT = (ADDR_W+1)'(TABLE_BYTES);
  localparam logic [SIZE_W-1:0] CB_WIDE = SIZE_W'(CLUSTER_BYTES);

  logic [7:0] mem [TABLE_BYTES];

  logic [CLUSTER_W-1:0] cur_q, cur_d;
  logic [SIZE_W-1:0]    rem_q, rem_d;
  logic                 active_q, active_d;
  logic [7:0]           rdata_q;
  logic                 rd_zero_q;
  logic [7:0]           lo_q;
  logic                 out_valid_q, out_valid_d;
  fcw_out_t             out_q, out_d;

  logic [ADDR_W-1:0]    rd_base, rd_lo_addr, rd_addr;
  logic [7:0]           byte_rd;
  logic [CLUSTER_W-1:0] entry;
  logic [CLUSTER_W-1:0] rep_c;
  logic [SIZE_W-1:0]    rep_rem;
  logic [VALID_W-1:0]   rep_valid;
  logic                 out_free;
  logic                 wr_ok;

  // entry of cluster c sits at (c/2)*3; even takes bytes 0,1 and odd bytes 1,2
  assign rd_base    = {2'b00, cur_q[CLUSTER_W-1:1]} + {1'b0, cur_q[CLUSTER_W-1:1], 1'b0};
  assign rd_lo_addr = rd_base + {{(ADDR_W-1){1'b0}}, cur_q[0]};
  assign rd_addr    = cmd_i.sel_hi ? rd_lo_addr + {{(ADDR_W-1){1'b0}}, 1'b1} : rd_lo_addr;
  assign wr_ok      = cmd_i.wr_en && ({1'b0, in_item_i.table_address} < TBL_LIMIT);

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem[in_item_i.table_address[AW-1:0]] <= in_item_i.table_byte;
    end
    rdata_q   <= mem[rd_addr[AW-1:0]];
    rd_zero_q <= ({1'b0, rd_addr} >= TBL_LIMIT);
    if (cmd_i.save_lo) begin
      lo_q <= byte_rd;
    end
  end

  assign byte_rd = rd_zero_q ? 8'h00 : rdata_q;
  assign entry   = cur_q[0] ? {byte_rd, lo_q[7:4]} : {byte_rd[3:0], lo_q};

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    rep_c       = cmd_i.rep_start ? in_item_i.start_cluster : entry;
    rep_rem     = cmd_i.rep_start ? in_item_i.file_size : rem_q;
    rep_valid   = (rep_rem < CB_WIDE) ? rep_rem[VALID_W-1:0] : VALID_W'(CLUSTER_BYTES);
    cur_d       = cur_q;
    rem_d       = rem_q;
    active_d    = active_q;
    out_d       = out_q;
    out_valid_d = out_stall_i ? out_valid_q : 1'b0;

    if (cmd_i.rep_start || cmd_i.rep_next) begin
      out_valid_d       = 1'b1;
      cur_d             = rep_c;
      rem_d             = rep_rem;
      active_d          = 1'b0;
      out_d.cluster     = rep_c;
      out_d.byte_offset = '0;
      out_d.bytes_valid = '0;
      priority if (rep_c >= END_MARK) begin
        out_d.status = ST_END;
      end else if (rep_c < FIRST_DATA_CLUSTER) begin
        // empty chain on start, free or reserved entry inside a chain
        out_d.status = cmd_i.rep_start ? ST_END : ST_BAD;
      end else if (rep_c >= BAD_MARK) begin
        out_d.status = ST_BAD;
      end else begin
        out_d.status      = ST_DATA;
        active_d          = 1'b1;
        out_d.byte_offset = {rep_c - FIRST_DATA_CLUSTER, 9'd0};
        out_d.bytes_valid = rep_valid;
        rem_d             = rep_rem - {{(SIZE_W-VALID_W){1'b0}}, rep_valid};
      end
    end else if (cmd_i.rep_idle) begin
      out_valid_d = 1'b1;
      out_d       = '{cluster: '0, byte_offset: '0, bytes_valid: '0, status: ST_IDLE};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      rem_q       <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_q       <= cur_d;
      rem_q       <= rem_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign sts_o.chain_active = active_q;
  assign sts_o.out_free     = out_free;
  assign out_valid_o        = out_valid_q;
  assign out_item_o         = out_q;

endmodule

FILE: rtl/core/fcw_ctrl.sv
// ----------------------------------------------------------------------------
// FAT12 cluster chain walker controller
// Accepts items and sequences the two table reads of an advance.
// ----------------------------------------------------------------------------
`include "fat12_cluster_chain_walker_top_defines.svh"

module fcw_ctrl import fcw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] kind_i,
  output logic       in_stall_o,
  input  fcw_sts_t   sts_i,
  output fcw_cmd_t   cmd_o
);

  fcw_state_e state_q, state_d;
  fcw_kind_e  kind;

  assign kind = fcw_kind_e'(kind_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = !sts_i.out_free;
        if (in_valid_i && sts_i.out_free) begin
          unique case (kind)
            KIND_LOAD:  cmd_o.wr_en     = 1'b1;
            KIND_START: cmd_o.rep_start = 1'b1;
            KIND_NEXT: begin
              // first entry byte is read at this edge
              if (sts_i.chain_active) begin
                state_d = S_READ;
              end else begin
                cmd_o.rep_idle = 1'b1;
              end
            end
            KIND_RSVD: ;
          endcase
        end
      end
      S_READ: begin
        cmd_o.sel_hi  = 1'b1;
        cmd_o.save_lo = 1'b1;
        state_d       = S_REPORT;
      end
      S_REPORT: begin
        cmd_o.sel_hi = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.rep_next = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  `FCW_ASSERT_NEXT(a_read_then_report, state_q == S_READ, state_q == S_REPORT,
                   "read step not followed by report")
  `FCW_ASSERT_NOW(a_report_needs_room, cmd_o.rep_start || cmd_o.rep_next || cmd_o.rep_idle,
                  sts_i.out_free, "report issued while output register is held")
  `FCW_ASSERT_NOW(a_single_report, cmd_o.rep_next,
                  !cmd_o.rep_start && !cmd_o.rep_idle && !cmd_o.wr_en,
                  "more than one action in a cycle")
  `FCW_ASSERT_NEXT(a_idle_advance_no_read,
                   state_q == S_IDLE && !in_stall_o && in_valid_i && kind == KIND_NEXT
                   && !sts_i.chain_active,
                   state_q == S_IDLE, "table read started with no active chain")

endmodule

FILE: rtl/core/fat12_cluster_chain_walker_top.sv
// ----------------------------------------------------------------------------
// FAT12 cluster chain walker
// Holds a FAT12 allocation table and walks one file's cluster chain.
// ----------------------------------------------------------------------------
// channel  | direction | handshake              | payload
// in       | input     | in_valid_i/in_stall_o  | in_item_i  (fcw_in_t)
// out      | output    | out_valid_o/out_stall_i| out_item_o (fcw_out_t)
//
// Load, start and advance with no active chain each complete without leaving idle.
// Advance on an active chain makes two dependent byte reads from the single
// read port of the table memory, then reports once the output has room.
// Reset is asynchronous; the table memory is not cleared.
// The input stalls while the output register holds a stalled item and during an advance.
// ----------------------------------------------------------------------------
module fat12_cluster_chain_walker_top import fcw_pkg::*; #(
  parameter int unsigned TABLE_BYTES = TABLE_BYTES_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  fcw_in_t  in_item_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output fcw_out_t out_item_o
);

  fcw_cmd_t cmd;
  fcw_sts_t sts;

  fcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (in_item_i.kind),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fcw_datapath #(
    .TABLE_BYTES (TABLE_BYTES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
